// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_CLK checks a property at each rising clock edge outside reset.
// ASSERT_NEVER checks that a condition is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/lph_pkg.sv
`timescale 1ns / 1ps

package lph_pkg;

    localparam int TABLE_SLOTS_DEF = 127;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;
        logic                j_home;
        logic                j_advance;
        logic                key_we;
        logic                key_zero;
        logic                data_we;
        logic                out_load;
        logic                keep_slot;
        logic                keep_data;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic            invalid;
        logic [OP_W-1:0] op;
        logic            mod_done;
        logic            match;
        logic            empty;
        logic            probe_last;
        logic            j_last;
    } stat_t;

endpackage

// File: rtl/lph_req_if.sv
`timescale 1ns / 1ps

interface lph_req_if;
    logic                        valid;
    logic                        ready;
    logic [lph_pkg::OP_W-1:0]    operation;
    logic [lph_pkg::KEY_W-1:0]   key;
    logic [lph_pkg::DATA_W-1:0]  data;

    modport source (output valid, output operation, output key, output data, input ready);
    modport sink   (input valid, input operation, input key, input data, output ready);
endinterface

// File: rtl/lph_rsp_if.sv
`timescale 1ns / 1ps

interface lph_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lph_pkg::STATUS_W-1:0]  status;
    logic [lph_pkg::SLOT_W-1:0]    slot;
    logic [lph_pkg::DATA_W-1:0]    found_data;

    modport source (output valid, output status, output slot, output found_data, input ready);
    modport sink   (input valid, input status, input slot, input found_data, output ready);
endinterface

// File: rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Open-addressing hash table with linear probing.
// req channel: operation (insert, delete, search), nonzero key, data word.
// rsp channel: one item per request with status, slot and found_data.
// An item is taken when valid and ready are both high at a rising edge.
// After reset the key memory is swept to empty, one slot per cycle, and
// req.ready stays low during the sweep.
// The home slot comes from a reciprocal-multiply remainder unit; the home
// address is then loaded and the probe walk reads one slot per cycle from
// the key memory. A request resolves on its k-th probe, k from 1 to
// TABLE_SLOTS; a zero key or unused operation is answered without probing.
// req.ready rises again in the cycle after the result register is loaded,
// so the block takes no new request until the previous one has resolved.
// The result sits in an output register: a new request is accepted while
// it waits, and a finished probe holds until rsp.ready frees the register.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    lph_req_if.sink      req,
    lph_rsp_if.source    rsp
);

    lph_pkg::cmd_t   cmd;
    lph_pkg::stat_t  st;

    // Sequence the sweep, the remainder wait and the probe walk.
    lph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Hold the request, the key and data memories and the result register.
    lph_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (req.operation),
        .key        (req.key),
        .data       (req.data),
        .cmd        (cmd),
        .st         (st),
        .status     (rsp.status),
        .slot       (rsp.slot),
        .found_data (rsp.found_data)
    );

endmodule

// File: rtl/lph_mod.sv
`timescale 1ns / 1ps

// Key modulo table size by reciprocal multiplication. The estimated quotient
// is at most one low, so one compare and subtract finishes the remainder.
// The product, then the raw remainder, are registered; done then rises with home ready.
module lph_mod #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lph_pkg::KEY_W-1:0]  value,
    output logic [$clog2(TABLE_SLOTS)-1:0] home,
    output logic                       done
);

    localparam int KW    = lph_pkg::KEY_W;
    localparam int IW    = $clog2(TABLE_SLOTS);
    localparam int SHIFT = KW - 1 + IW;
    localparam logic [IW:0]   MODULUS    = (IW + 1)'(TABLE_SLOTS);
    localparam logic [63:0]   RECIP_WIDE = (64'd1 << SHIFT) / 64'(TABLE_SLOTS);
    localparam logic [KW-1:0] RECIP      = RECIP_WIDE[KW-1:0];

    logic [1:0]       cnt_reg;
    logic [KW-1:0]    key_reg;
    logic [2*KW-1:0]  prod_reg;
    logic [IW:0]      quot_low;
    logic [IW:0]      qp_low;
    logic [IW:0]      rem_reg;
    logic [IW:0]      rem_fix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 2'd2;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Only the low bits of quotient times modulus matter: the remainder
    // estimate is below twice the modulus.
    assign quot_low = prod_reg[SHIFT +: IW + 1];
    assign qp_low   = quot_low * MODULUS;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= value;
        end
        if (cnt_reg == 2'd2)
        begin
            prod_reg <= {{KW{1'b0}}, key_reg} * {{KW{1'b0}}, RECIP};
        end
        if (cnt_reg == 2'd1)
        begin
            rem_reg <= key_reg[IW:0] - qp_low;
        end
    end

    assign rem_fix = (rem_reg >= MODULUS) ? (rem_reg - MODULUS) : rem_reg;
    assign home    = rem_fix[IW-1:0];
    assign done    = (cnt_reg == '0);

endmodule

// File: rtl/lph_dp.sv
`timescale 1ns / 1ps

module lph_dp #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lph_pkg::OP_W-1:0]      operation,
    input  logic [lph_pkg::KEY_W-1:0]     key,
    input  logic [lph_pkg::DATA_W-1:0]    data,
    input  lph_pkg::cmd_t                 cmd,
    output lph_pkg::stat_t                st,
    output logic [lph_pkg::STATUS_W-1:0]  status,
    output logic [lph_pkg::SLOT_W-1:0]    slot,
    output logic [lph_pkg::DATA_W-1:0]    found_data
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

    logic [lph_pkg::OP_W-1:0]    op_reg;
    logic [lph_pkg::KEY_W-1:0]   key_reg;
    logic [lph_pkg::DATA_W-1:0]  data_reg;

    logic [IW-1:0] j_reg, j_next, j_inc;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] home;
    logic          mod_done;

    logic [lph_pkg::KEY_W-1:0]   key_mem [TABLE_SLOTS];
    logic [lph_pkg::DATA_W-1:0]  data_mem [TABLE_SLOTS];
    logic [lph_pkg::KEY_W-1:0]   key_q;
    logic [lph_pkg::DATA_W-1:0]  data_q;

    logic [IW+lph_pkg::SLOT_W-1:0] slot_ext;

    logic [lph_pkg::STATUS_W-1:0]  status_reg;
    logic [lph_pkg::SLOT_W-1:0]    slot_reg;
    logic [lph_pkg::DATA_W-1:0]    fdata_reg;

    lph_mod #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.capture),
        .value (key),
        .home  (home),
        .done  (mod_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            key_reg  <= key;
            data_reg <= data;
        end
    end

    assign j_inc = (j_reg == LAST) ? '0 : (j_reg + {{(IW-1){1'b0}}, 1'b1});

    always_comb
    begin
        j_next   = j_reg;
        cnt_next = cnt_reg;
        if (cmd.j_home)
        begin
            j_next   = home;
            cnt_next = '0;
        end
        else if (cmd.j_advance)
        begin
            j_next   = j_inc;
            cnt_next = cnt_reg + {{(IW-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            j_reg   <= j_next;
            cnt_reg <= cnt_next;
        end
    end

    // Read at the next probe address so the word for j_reg is ready with it.
    always_ff @(posedge clk)
    begin
        if (cmd.key_we)
        begin
            key_mem[j_reg] <= cmd.key_zero ? '0 : key_reg;
        end
        key_q <= key_mem[j_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data_we)
        begin
            data_mem[j_reg] <= data_reg;
        end
        data_q <= data_mem[j_next];
    end

    assign slot_ext = {{lph_pkg::SLOT_W{1'b0}}, j_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.status;
            slot_reg   <= cmd.keep_slot ? slot_ext[lph_pkg::SLOT_W-1:0] : '0;
            fdata_reg  <= cmd.keep_data ? data_q : '0;
        end
    end

    assign st.invalid    = (key_reg == '0) ||
                           !((op_reg == lph_pkg::OP_INSERT) ||
                             (op_reg == lph_pkg::OP_DELETE) ||
                             (op_reg == lph_pkg::OP_SEARCH));
    assign st.op         = op_reg;
    assign st.mod_done   = mod_done;
    assign st.match      = (key_q == key_reg);
    assign st.empty      = (key_q == '0);
    assign st.probe_last = (cnt_reg == LAST);
    assign st.j_last     = (j_reg == LAST);

    assign status     = status_reg;
    assign slot       = slot_reg;
    assign found_data = fdata_reg;

endmodule

// File: rtl/lph_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lph_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  lph_pkg::stat_t  st,
    output lph_pkg::cmd_t   cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MOD   = 2'd2;
    localparam logic [1:0] S_PROBE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.j_advance = 1'b1;
                cmd.key_we    = 1'b1;
                cmd.key_zero  = 1'b1;
                if (st.j_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MOD;
                end
            end
            S_MOD:
            begin
                if (st.invalid)
                begin
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.status   = lph_pkg::ST_INVALID;
                        state_next   = S_IDLE;
                    end
                end
                else if (st.mod_done)
                begin
                    cmd.j_home = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (st.op == lph_pkg::OP_INSERT)
                begin
                    if (st.match)
                    begin
                        if (out_free)
                        begin
                            cmd.out_load  = 1'b1;
                            cmd.keep_slot = 1'b1;
                            cmd.status    = lph_pkg::ST_PRESENT;
                            state_next    = S_IDLE;
                        end
                    end
                    else if (st.empty)
                    begin
                        if (out_free)
                        begin
                            cmd.key_we    = 1'b1;
                            cmd.data_we   = 1'b1;
                            cmd.out_load  = 1'b1;
                            cmd.keep_slot = 1'b1;
                            cmd.status    = lph_pkg::ST_INSERTED;
                            state_next    = S_IDLE;
                        end
                    end
                    else if (st.probe_last)
                    begin
                        if (out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.status   = lph_pkg::ST_FULL;
                            state_next   = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.j_advance = 1'b1;
                    end
                end
                else
                begin
                    // Search and delete step over empty slots.
                    if (st.match)
                    begin
                        if (out_free)
                        begin
                            cmd.out_load  = 1'b1;
                            cmd.keep_slot = 1'b1;
                            cmd.keep_data = 1'b1;
                            if (st.op == lph_pkg::OP_DELETE)
                            begin
                                cmd.key_we   = 1'b1;
                                cmd.key_zero = 1'b1;
                                cmd.status   = lph_pkg::ST_DELETED;
                            end
                            else
                            begin
                                cmd.status   = lph_pkg::ST_FOUND;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    else if (st.probe_last)
                    begin
                        if (out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.status   = lph_pkg::ST_MISSING;
                            state_next   = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.j_advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    `ASSERT_NEVER(a_no_result_overwrite, clk, rst_n, cmd.out_load && out_valid_reg && !rsp_ready, "result overwritten while held")
    `ASSERT_NEVER(a_data_with_key, clk, rst_n, cmd.data_we && !(cmd.key_we && !cmd.key_zero), "data written without its key")
    `ASSERT_CLK(a_accept_starts, clk, rst_n, (req_valid && req_ready) |=> (state_reg == S_MOD), "accepted item did not start")
    `ASSERT_CLK(a_load_ends, clk, rst_n, cmd.out_load |=> (state_reg == S_IDLE) && rsp_valid, "result load did not finish item")

endmodule

// File: tb/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;

    localparam int SLOTS          = lph_pkg::TABLE_SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 200;
    localparam int LONG_HOLD      = 600;

    // Operation code the block does not define; it must answer ST_INVALID.
    localparam logic [lph_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [lph_pkg::STATUS_W-1:0] status;
        logic [lph_pkg::SLOT_W-1:0]   slot;
        logic [lph_pkg::DATA_W-1:0]   found_data;
    } answer_t;

    logic clk;
    logic rst_n;

    lph_req_if req_if ();
    lph_rsp_if rsp_if ();

    linear_probe_hash_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // Shadow copy of the table contents, updated as each item is accepted.
    logic [lph_pkg::KEY_W-1:0]  shadow_keys [SLOTS];
    logic [lph_pkg::DATA_W-1:0] shadow_data [SLOTS];
    int                         occupied;

    // Answers the block still owes, oldest first.
    answer_t pending_answers [$];
    answer_t front_answer;

    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    int rsp_hold_left;
    int quiet_cycles;

    // Free-running clock, 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Work out the answer to one request and apply its effect to the shadow table.
    function automatic answer_t apply_to_shadow_table(logic [lph_pkg::OP_W-1:0] op,
                                                      logic [lph_pkg::KEY_W-1:0] key,
                                                      logic [lph_pkg::DATA_W-1:0] data);
        answer_t ans;
        int      home;
        int      j;
        int      n;
        bit      done;
        ans.status     = lph_pkg::ST_INVALID;
        ans.slot       = '0;
        ans.found_data = '0;
        done           = 1'b0;
        if (key != '0 && (op == lph_pkg::OP_INSERT || op == lph_pkg::OP_DELETE ||
                          op == lph_pkg::OP_SEARCH))
        begin
            home = key % SLOTS;
            j    = home;
            if (op == lph_pkg::OP_INSERT)
            begin
                // Stop at the same key or the first empty slot; a full lap means full.
                ans.status = lph_pkg::ST_FULL;
                for (n = 0; n < SLOTS && !done; n++)
                begin
                    if (shadow_keys[j] == key)
                    begin
                        ans.status = lph_pkg::ST_PRESENT;
                        ans.slot   = j[lph_pkg::SLOT_W-1:0];
                        done       = 1'b1;
                    end
                    else if (shadow_keys[j] == '0)
                    begin
                        shadow_keys[j] = key;
                        shadow_data[j] = data;
                        occupied++;
                        ans.status = lph_pkg::ST_INSERTED;
                        ans.slot   = j[lph_pkg::SLOT_W-1:0];
                        done       = 1'b1;
                    end
                    else
                        j = (j + 1) % SLOTS;
                end
            end
            else
            begin
                // Search and delete walk past empty slots; only a match stops them.
                ans.status = lph_pkg::ST_MISSING;
                for (n = 0; n < SLOTS && !done; n++)
                begin
                    if (shadow_keys[j] == key)
                    begin
                        ans.slot       = j[lph_pkg::SLOT_W-1:0];
                        ans.found_data = shadow_data[j];
                        if (op == lph_pkg::OP_DELETE)
                        begin
                            // Clear the key only; the data word stays behind.
                            shadow_keys[j] = '0;
                            occupied--;
                            ans.status = lph_pkg::ST_DELETED;
                        end
                        else
                            ans.status = lph_pkg::ST_FOUND;
                        done = 1'b1;
                    end
                    else
                        j = (j + 1) % SLOTS;
                end
            end
        end
        return ans;
    endfunction

    // Draw a key: often one already stored, else a colliding cluster, zero, or anything.
    function automatic logic [lph_pkg::KEY_W-1:0] pick_key(int stored_pct);
        int roll;
        int j;
        roll = $urandom_range(0, 99);
        j    = $urandom_range(0, SLOTS - 1);
        if (roll < stored_pct && shadow_keys[j] != '0)
            return shadow_keys[j];
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        // Homes around the top of the table, so probe chains wrap through slot 0.
        if (roll < 60)
            return SLOTS * $urandom_range(1, 6) + ($urandom_range(110, 146) % SLOTS);
        return $urandom();
    endfunction

    // Offer one item, hold it until taken, and queue its answer.
    task automatic send_request(logic [lph_pkg::OP_W-1:0] op,
                                logic [lph_pkg::KEY_W-1:0] key,
                                logic [lph_pkg::DATA_W-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.key       <= key;
        req_if.data      <= data;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_answers.push_back(apply_to_shadow_table(op, key, data));
        @(negedge clk);
    endtask

    // Drop valid and wait until every queued answer has come back.
    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s differs: expected %0h, got %0h", $realtime, field, want, got);
    endtask

    // Edge cases: invalid keys and codes, slot 0 handling, wraparound, extremes.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(lph_pkg::OP_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_request(lph_pkg::OP_DELETE, 32'd0, 32'd0);
        send_request(lph_pkg::OP_SEARCH, 32'd0, 32'd0);
        send_request(OP_UNUSED, 32'd5, 32'd7);
        send_request(lph_pkg::OP_INSERT, 32'd127, 32'hFFFF_FFFF);   // home slot 0
        send_request(lph_pkg::OP_INSERT, 32'd254, 32'd0);           // collides, lands in slot 1
        send_request(lph_pkg::OP_INSERT, 32'd254, 32'h1234_5678);   // already present, data kept
        send_request(lph_pkg::OP_SEARCH, 32'd254, 32'd0);
        send_request(lph_pkg::OP_DELETE, 32'd127, 32'd0);           // delete out of slot 0
        send_request(lph_pkg::OP_SEARCH, 32'd127, 32'd0);
        send_request(lph_pkg::OP_SEARCH, 32'd254, 32'd0);           // walk past the empty slot 0
        send_request(lph_pkg::OP_INSERT, 32'd126, 32'hA5A5_A5A5);   // last slot
        send_request(lph_pkg::OP_INSERT, 32'd253, 32'h0000_0001);   // wraps into slot 0
        send_request(lph_pkg::OP_INSERT, 32'd380, 32'h8000_0000);   // wraps past slots 0 and 1
        send_request(lph_pkg::OP_SEARCH, 32'd380, 32'd0);
        send_request(lph_pkg::OP_DELETE, 32'd253, 32'd0);
        send_request(lph_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_request(lph_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'd0);
        send_request(lph_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'd0);
        send_request(lph_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'd0);     // gone now
        send_request(lph_pkg::OP_SEARCH, 32'd1, 32'd0);             // full lap, not found
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(lph_pkg::OP_INSERT, 32'd1, 32'd1);
        wait_drain();
    endtask

    // Mixed traffic over a small key space so chains grow, collide and wrap.
    task automatic test_random(int count, int idle_pct, int stall_pct);
        int                       i;
        int                       roll;
        logic [lph_pkg::OP_W-1:0] op;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                send_request(lph_pkg::OP_INSERT, pick_key(15), $urandom());
            else
            begin
                if (roll < 65)
                    op = lph_pkg::OP_DELETE;
                else if (roll < 97)
                    op = lph_pkg::OP_SEARCH;
                else
                    op = OP_UNUSED;
                send_request(op, pick_key(65), $urandom());
            end
        end
        wait_drain();
    endtask

    // Fill every slot, hit the table-full path, probe a full table, then free some slots.
    task automatic test_table_full();
        int i;
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        while (occupied < SLOTS)
            send_request(lph_pkg::OP_INSERT, $urandom() | 32'h1, $urandom());
        for (i = 0; i < 3; i++)
            send_request(lph_pkg::OP_INSERT, $urandom() | 32'h1, $urandom());
        send_request(lph_pkg::OP_INSERT, shadow_keys[$urandom_range(0, SLOTS - 1)],
                     $urandom());
        send_request(lph_pkg::OP_SEARCH, $urandom() | 32'h1, 32'd0);
        for (i = 0; i < 6; i++)
            send_request(lph_pkg::OP_DELETE, shadow_keys[$urandom_range(0, SLOTS - 1)],
                         32'd0);
        send_request(lph_pkg::OP_INSERT, $urandom() | 32'h1, $urandom());
        wait_drain();
    endtask

    // Hold off the receiver long enough that the block stops taking items.
    task automatic test_backpressure();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rsp_hold_left  = LONG_HOLD;
        for (i = 0; i < 16; i++)
            send_request(i % 3 == 0 ? lph_pkg::OP_INSERT : lph_pkg::OP_SEARCH,
                         pick_key(50), $urandom());
        // Pause the sender until everything has come back.
        wait_drain();
    endtask

    // Receiver: honor a requested long hold, otherwise stall at the current rate.
    always @(negedge clk)
    begin
        if (rsp_hold_left > 0)
        begin
            rsp_hold_left = rsp_hold_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each answer taken against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_answers.size() == 0)
                note_mismatch("unexpected answer, status", '0, 32'(rsp_if.status));
            else
            begin
                front_answer = pending_answers.pop_front();
                if (rsp_if.status !== front_answer.status)
                    note_mismatch("status", 32'(front_answer.status), 32'(rsp_if.status));
                if (rsp_if.slot !== front_answer.slot)
                    note_mismatch("slot", 32'(front_answer.slot), 32'(rsp_if.slot));
                if (rsp_if.found_data !== front_answer.found_data)
                    note_mismatch("found_data", front_answer.found_data, rsp_if.found_data);
            end
        end
    end

    // Watchdog: count cycles with no item moving on either channel.
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = lph_pkg::OP_INSERT;
        req_if.key       = '0;
        req_if.data      = '0;
        rsp_if.ready     = 1'b0;
        mismatches       = 0;
        occupied         = 0;
        quiet_cycles     = 0;
        rsp_hold_left    = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_keys[i] = '0;
            shadow_data[i] = '0;
        end

        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random(360, 0, 0);
        test_random(360, 54, 0);
        test_table_full();
        test_backpressure();
        test_random(360, 0, 54);
        test_random(360, 15, 15);

        // Let the block settle, then report.
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lph_pkg.sv
rtl/lph_req_if.sv
rtl/lph_rsp_if.sv
rtl/lph_mod.sv
rtl/lph_dp.sv
rtl/lph_ctrl.sv
rtl/linear_probe_hash_table.sv
tb/tb_linear_probe_hash_table.sv
